/* sv/hmn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Height map to normal map package
// Shared types and constants of the normal map block.
// ----------------------------------------------------------------------------
package hmn_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned AddrW     = ColW + RowW;
  localparam int unsigned HeightW   = 10;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned SumW      = 53;
  localparam int unsigned RootW     = 27;

  localparam logic [CfgIdxW-1:0] RegBumpScale   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd2;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] col;
    logic [7:0] row;
  } in_word_t;

  typedef struct packed {
    logic [7:0] normal_red;
    logic [7:0] normal_green;
    logic [7:0] normal_blue;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic rd_issue;
    logic [2:0] rd_sel;
    logic rd_capture;
    logic [3:0] cap_sel;
    logic grad;
    logic sq_x;
    logic sq_y;
    logic sq_z;
    logic sqrt_start;
    logic div_start;
    logic emit;
  } hmn_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
  } hmn_stat_t;

endpackage

/* sv/hmn_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Normal map controller
// Sequences neighbor reads, squaring, root and the three divisions.
// ----------------------------------------------------------------------------
module hmn_ctrl
  import hmn_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      kind_i,
  input  hmn_stat_t stat_i,
  output logic      busy_o,
  output hmn_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    StIdle, StRead, StSquare, StRoot, StDiv, StEmit
  } state_e;

  state_e     state_q;
  logic [3:0] cnt_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = start_i && !busy_o && kind_i == KindLoad;
    cmd_o.rd_sel = cnt_q[2:0];
    cmd_o.cap_sel = cnt_q - 4'd1;
    if (state_q == StRead) begin
      cmd_o.rd_issue = cnt_q < 4'd8;
      cmd_o.rd_capture = cnt_q != 4'd0;
      cmd_o.grad = cnt_q == 4'd9;
    end
    if (state_q == StSquare) begin
      cmd_o.sq_x = cnt_q == 4'd0;
      cmd_o.sq_y = cnt_q == 4'd1;
      cmd_o.sq_z = cnt_q == 4'd2;
      cmd_o.sqrt_start = cnt_q == 4'd3;
    end
    cmd_o.div_start = state_q == StRoot && stat_i.sqrt_done;
    cmd_o.emit = state_q == StEmit;
  end

  assign busy_o = state_q != StIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          cnt_q <= '0;
          if (start_i && kind_i == KindQuery) state_q <= StRead;
        end
        StRead: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd9) begin
            cnt_q <= '0;
            state_q <= StSquare;
          end
        end
        StSquare: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd3) state_q <= StRoot;
        end
        StRoot: if (stat_i.sqrt_done) state_q <= StDiv;
        StDiv: if (stat_i.div_done) state_q <= StEmit;
        StEmit: state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

/* sv/hmn_path.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Normal map datapath
// Frame store, Sobel gradients, squared length, root and byte division.
// ----------------------------------------------------------------------------
module hmn_path
  import hmn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  in_word_t            in_word_i,
  input  logic                start_i,
  input  hmn_cmd_t            cmd_i,
  input  logic [CfgDataW-1:0] bump_i,
  input  logic [8:0]          width_i,
  input  logic [8:0]          height_i,
  output hmn_stat_t           stat_o,
  output out_word_t           result_o
);

  logic [HeightW-1:0] mem_q [MaxWidth*MaxHeight];
  logic [HeightW-1:0] rd_q;
  logic [HeightW-1:0] nb_q [8];
  logic [7:0] c_q, r_q;
  logic [ColW-1:0] cl, cr, rc;
  logic [RowW-1:0] rb, rt, rr;
  logic [8:0] w_eff, h_eff;
  logic signed [15:0] dx_q, dy_q;
  logic signed [24:0] vx_q, vy_q;
  logic [25:0] vz_q;
  logic [SumW-1:0] sum_q;
  logic [SumW-1:0] rem_q, res_q, bit_q;
  logic sq_busy_q, dv_busy_q;
  logic [RootW-1:0] len_q;
  logic [1:0] dv_ch_q;
  logic [4:0] dv_cnt_q;
  logic [37:0] num_q;
  logic [7:0] quo_q;
  logic [7:0] b_q [3];
  logic signed [12:0] sx, sy;

  always_comb begin
    w_eff = (width_i == 9'd0) ? 9'd1 : (width_i > 9'(MaxWidth)) ? 9'(MaxWidth) : width_i;
    h_eff = (height_i == 9'd0) ? 9'd1 : (height_i > 9'(MaxHeight)) ? 9'(MaxHeight) : height_i;
    cl = (c_q == 8'd0) ? ColW'(w_eff - 9'd1) : ColW'(c_q - 8'd1);
    cr = ({1'b0, c_q} + 9'd1 < w_eff) ? ColW'(c_q + 8'd1) : '0;
    rb = (r_q == 8'd0) ? RowW'(h_eff - 9'd1) : RowW'(r_q - 8'd1);
    rt = ({1'b0, r_q} + 9'd1 < h_eff) ? RowW'(r_q + 8'd1) : '0;
    rc = c_q;
    rr = r_q;
    // Order: T, B, L, R, TL, BL, TR, BR.
    sx = 13'($signed({3'b0, nb_q[6]})) - 13'($signed({3'b0, nb_q[4]}))
       + 13'(2 * ($signed({3'b0, nb_q[3]}) - $signed({3'b0, nb_q[2]})))
       + 13'($signed({3'b0, nb_q[7]})) - 13'($signed({3'b0, nb_q[5]}));
    sy = 13'($signed({3'b0, nb_q[5]})) - 13'($signed({3'b0, nb_q[4]}))
       + 13'(2 * ($signed({3'b0, nb_q[1]}) - $signed({3'b0, nb_q[0]})))
       + 13'($signed({3'b0, nb_q[7]})) - 13'($signed({3'b0, nb_q[6]}));
  end

  logic [ColW-1:0] ac;
  logic [RowW-1:0] ar;
  always_comb begin
    case (cmd_i.rd_sel)
      3'd0: begin ac = rc; ar = rt; end
      3'd1: begin ac = rc; ar = rb; end
      3'd2: begin ac = cl; ar = rr; end
      3'd3: begin ac = cr; ar = rr; end
      3'd4: begin ac = cl; ar = rt; end
      3'd5: begin ac = cl; ar = rb; end
      3'd6: begin ac = cr; ar = rt; end
      default: begin ac = cr; ar = rb; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem_q[{in_word_i.row, in_word_i.col}] <= HeightW'(in_word_i.red_in)
        + HeightW'(in_word_i.green_in) + HeightW'(in_word_i.blue_in);
    end
    if (cmd_i.rd_issue) rd_q <= mem_q[{ar, ac}];
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      c_q <= in_word_i.col;
      r_q <= in_word_i.row;
    end
    if (cmd_i.rd_capture) nb_q[cmd_i.cap_sel[2:0]] <= rd_q;
    if (cmd_i.grad) begin
      dx_q <= 16'(sx);
      dy_q <= 16'(sy);
      vx_q <= -25'(sx) * 25'sd256;
      vy_q <= -25'(sy) * 25'sd256;
      vz_q <= 26'(bump_i) * 26'd765;
    end
    if (cmd_i.sq_x) sum_q <= SumW'(dx_q * dx_q) << 16;
    if (cmd_i.sq_y) sum_q <= sum_q + (SumW'(dy_q * dy_q) << 16);
    if (cmd_i.sq_z) sum_q <= sum_q + SumW'(vz_q * vz_q);
  end

  // Restoring square root, one result bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
    end else if (cmd_i.sqrt_start) begin
      sq_busy_q <= 1'b1;
      rem_q <= sum_q;
      res_q <= '0;
      bit_q <= SumW'(1) << (SumW - 1);
    end else if (sq_busy_q) begin
      if (bit_q == '0) begin
        sq_busy_q <= 1'b0;
        len_q <= RootW'(res_q);
      end else begin
        if (rem_q >= res_q + bit_q) begin
          rem_q <= rem_q - (res_q + bit_q);
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
    end
  end
  assign stat_o.sqrt_done = sq_busy_q && bit_q == '0;

  // Restoring division: (255*(L+v)+L) / (2L), 8 quotient bits per channel.
  logic signed [28:0] vsel;
  logic [37:0] num0;
  logic [37:0] dshift;
  always_comb begin
    case (dv_ch_q)
      2'd0: vsel = 29'(vx_q);
      2'd1: vsel = 29'(vy_q);
      default: vsel = $signed({3'b0, vz_q});
    endcase
    num0 = 38'(({11'b0, len_q} + 38'($signed(vsel))) * 38'd255) + 38'(len_q);
    dshift = 38'({len_q, 1'b0}) << dv_cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_busy_q <= 1'b0;
      dv_ch_q <= '0;
      dv_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dv_busy_q <= 1'b1;
      dv_ch_q <= '0;
      dv_cnt_q <= 5'd8;
      num_q <= '0;
      quo_q <= '0;
    end else if (dv_busy_q) begin
      if (dv_cnt_q == 5'd8 && num_q == '0 && quo_q == '0) begin
        num_q <= num0;
        quo_q <= 8'd1;
        dv_cnt_q <= 5'd9;
      end else if (dv_cnt_q == 5'd9) begin
        quo_q <= '0;
        dv_cnt_q <= 5'd7;
        if (num_q >= (38'({len_q, 1'b0}) << 8)) begin
          quo_q <= 8'd255;
          dv_cnt_q <= 5'd31;
        end
      end else if (dv_cnt_q == 5'd31 || (dv_cnt_q == 5'd0 && quo_q[0] == quo_q[0] && 1'b0)) begin
        dv_cnt_q <= 5'd30;
      end else begin
        if (dv_cnt_q != 5'd30 && num_q >= dshift) begin
          num_q <= num_q - dshift;
          quo_q[dv_cnt_q[2:0]] <= 1'b1;
        end
        if (dv_cnt_q == 5'd0 || dv_cnt_q == 5'd30) begin
          b_q[dv_ch_q] <= (len_q == '0) ? ((dv_ch_q == 2'd2) ? 8'd255 : 8'd128)
                        : ((dv_cnt_q == 5'd0 && num_q >= dshift) ? (quo_q | 8'd1) : quo_q);
          num_q <= '0;
          quo_q <= '0;
          dv_cnt_q <= 5'd8;
          if (dv_ch_q == 2'd2) dv_busy_q <= 1'b0;
          else dv_ch_q <= dv_ch_q + 2'd1;
        end else begin
          dv_cnt_q <= dv_cnt_q - 5'd1;
        end
      end
    end
  end
  assign stat_o.div_done = dv_busy_q && dv_ch_q == 2'd2
    && (dv_cnt_q == 5'd0 || dv_cnt_q == 5'd30);

  assign result_o.normal_red = b_q[0];
  assign result_o.normal_green = b_q[1];
  assign result_o.normal_blue = b_q[2];

endmodule

/* sv/height_map_to_normal_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Height map to normal map
// Loads pixel heights and returns Sobel normals as RGB bytes.
// ----------------------------------------------------------------------------
// Loads can follow back to back. A query holds busy while it runs the eight reads
// from the single-port frame store, squaring, the bit-serial square root, three
// serial divisions and the emit. done_o rises in the same cycle that busy falls.
// One query is in flight at a time, and no load or query is taken while busy.
// Reset clears control state and registers; the frame store is undefined.
module height_map_to_normal_map
  import hmn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  in_word_t            in_word_i,
  output logic                done_o,
  output out_word_t           out_word_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  hmn_cmd_t  cmd;
  hmn_stat_t stat;
  logic [15:0] bump_q;
  logic [8:0]  width_q, height_q;
  logic        acc;

  assign acc = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bump_q <= 16'd512;
      width_q <= 9'd256;
      height_q <= 9'd256;
      done_o <= 1'b0;
    end else begin
      done_o <= cmd.emit;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegBumpScale: bump_q <= cfg_data_i;
          RegFrameWidth: width_q <= cfg_data_i[8:0];
          RegFrameHeight: height_q <= cfg_data_i[8:0];
          default: ;
        endcase
      end
    end
  end

  hmn_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .kind_i(in_word_i.kind),
    .stat_i(stat), .busy_o(busy), .cmd_o(cmd)
  );

  out_word_t res;
  hmn_path u_path (
    .clk_i, .rst_ni, .in_word_i, .start_i(acc), .cmd_i(cmd),
    .bump_i(bump_q), .width_i(width_q), .height_i(height_q),
    .stat_o(stat), .result_o(res)
  );

  always_ff @(posedge clk_i) begin
    if (cmd.emit) out_word_o <= res;
  end

endmodule

/* sv/hmn_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Normal map port checker
// Checks port behavior over time.
// ----------------------------------------------------------------------------
module hmn_checker
  import hmn_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input in_word_t in_word_i,
  input logic     done_o
);

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_word_i.kind == KindQuery |=> busy) else $error("no busy");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_word_i.kind == KindLoad |=> !busy) else $error("load busy");

endmodule

bind height_map_to_normal_map hmn_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .in_word_i, .done_o
);

/* bench/height_map_to_normal_map_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Height map to normal map testbench
// Loads pixel heights and queries Sobel normals under several frame sizes and
// bump scales, with random bursts and gaps on the input side. A scoreboard
// keeps its own copy of the frame store and registers, predicts each normal
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module height_map_to_normal_map_tb;
  import hmn_pkg::*;

  class normal_scoreboard;
    logic [HeightW-1:0] heights[int];
    logic [15:0]        bump;
    logic [8:0]         frame_w;
    logic [8:0]         frame_h;
    out_word_t          pending[$];
    int                 errors;
    int                 n_loads;
    int                 n_queries;

    function new();
      bump = 16'd512;
      frame_w = 9'd256;
      frame_h = 9'd256;
      errors = 0;
      n_loads = 0;
      n_queries = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegBumpScale: bump = data;
        RegFrameWidth: frame_w = data[8:0];
        RegFrameHeight: frame_h = data[8:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_size(logic [8:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function void neighbours(input int c, input int r,
                             output int cl, output int cr, output int rb, output int rt);
      int unsigned w;
      int unsigned h;
      w = eff_size(frame_w, MaxWidth);
      h = eff_size(frame_h, MaxHeight);
      cl = (c == 0) ? w - 1 : c - 1;
      cr = (c + 1 < w) ? c + 1 : 0;
      rb = (r == 0) ? h - 1 : r - 1;
      rt = (r + 1 < h) ? r + 1 : 0;
    endfunction

    function bit is_loaded(int c, int r);
      return heights.exists(r * MaxWidth + c);
    endfunction

    function longint height_at(int c, int r);
      if (heights.exists(r * MaxWidth + c)) return longint'(heights[r * MaxWidth + c]);
      return 0;
    endfunction

    function longint unsigned isqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned probe;
      res = 0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
        if (n >= res + probe) begin
          n = n - (res + probe);
          res = (res >> 1) + probe;
        end else begin
          res = res >> 1;
        end
        probe = probe >> 2;
      end
      return res;
    endfunction

    function logic [7:0] to_byte(longint v, longint len);
      longint q;
      q = (255 * (len + v) + len) / (2 * len);
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      return q[7:0];
    endfunction

    function void note_input(in_word_t w);
      int cl, cr, rb, rt;
      longint dx, dy, vx, vy, vz, len;
      out_word_t exp_word;
      if (w.kind == KindLoad) begin
        heights[int'(w.row) * MaxWidth + int'(w.col)] =
          10'(w.red_in) + 10'(w.green_in) + 10'(w.blue_in);
        n_loads++;
        return;
      end
      n_queries++;
      neighbours(w.col, w.row, cl, cr, rb, rt);
      dx = height_at(cr, rt) - height_at(cl, rt) + 2 * (height_at(cr, w.row) - height_at(cl, w.row))
         + height_at(cr, rb) - height_at(cl, rb);
      dy = height_at(cl, rb) - height_at(cl, rt) + 2 * (height_at(w.col, rb) - height_at(w.col, rt))
         + height_at(cr, rb) - height_at(cr, rt);
      vx = -256 * dx;
      vy = -256 * dy;
      vz = 765 * longint'(bump);
      len = longint'(isqrt(longint'(vx * vx + vy * vy + vz * vz)));
      if (len == 0) begin
        exp_word = '{normal_red: 8'd128, normal_green: 8'd128, normal_blue: 8'd255};
      end else begin
        exp_word.normal_red = to_byte(vx, len);
        exp_word.normal_green = to_byte(vy, len);
        exp_word.normal_blue = to_byte(vz, len);
      end
      pending.push_back(exp_word);
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_word;
      if (pending.size() == 0) begin
        $error("unexpected normal word %h", got);
        errors++;
        return;
      end
      exp_word = pending.pop_front();
      if (got.normal_red !== exp_word.normal_red) begin
        $error("normal_red expected %0d actual %0d", exp_word.normal_red, got.normal_red);
        errors++;
      end
      if (got.normal_green !== exp_word.normal_green) begin
        $error("normal_green expected %0d actual %0d", exp_word.normal_green, got.normal_green);
        errors++;
      end
      if (got.normal_blue !== exp_word.normal_blue) begin
        $error("normal_blue expected %0d actual %0d", exp_word.normal_blue, got.normal_blue);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  in_word_t            in_word_i;
  logic                done_o;
  out_word_t           out_word_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  normal_scoreboard sb = new();
  int  idle_cycles = 0;
  int  burst_left = 0;
  bit  use_gaps = 1'b1;

  height_map_to_normal_map uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_word_i(in_word_i),
    .done_o(done_o), .out_word_o(out_word_o), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(out_word_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("watchdog expired with %0d normals outstanding", sb.pending.size());
        $display("** height_map_to_normal_map: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_word(in_word_t w);
    if (use_gaps && burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    start <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_input(w);
  endtask

  task automatic load_pixel(int c, int r);
    in_word_t w;
    w.kind = KindLoad;
    w.col = c[7:0];
    w.row = r[7:0];
    case ($urandom_range(0, 5))
      0: {w.red_in, w.green_in, w.blue_in} = '0;
      1: {w.red_in, w.green_in, w.blue_in} = '1;
      default: {w.red_in, w.green_in, w.blue_in} = 24'($urandom);
    endcase
    send_word(w);
  endtask

  task automatic query_pixel(int c, int r);
    int cl, cr, rb, rt;
    int cs[3];
    int rs[3];
    in_word_t w;
    sb.neighbours(c, r, cl, cr, rb, rt);
    cs = '{cl, c, cr};
    rs = '{rb, r, rt};
    foreach (cs[i]) begin
      foreach (rs[j]) begin
        if (!(i == 1 && j == 1) && !sb.is_loaded(cs[i], rs[j])) load_pixel(cs[i], rs[j]);
      end
    end
    w = 'x;
    w.kind = KindQuery;
    {w.red_in, w.green_in, w.blue_in} = 24'($urandom);
    w.col = c[7:0];
    w.row = r[7:0];
    send_word(w);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0 || busy) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic set_frame(logic [15:0] bump, logic [15:0] fw, logic [15:0] fh);
    wait_idle();
    write_reg(RegBumpScale, bump);
    write_reg(RegFrameWidth, fw);
    write_reg(RegFrameHeight, fh);
  endtask

  task automatic random_items(int count);
    int unsigned w;
    int unsigned h;
    int c, r;
    w = sb.eff_size(sb.frame_w, MaxWidth);
    h = sb.eff_size(sb.frame_h, MaxHeight);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        c = $urandom_range(0, 255);
        r = $urandom_range(0, 255);
      end else begin
        c = $urandom_range(0, w - 1);
        r = $urandom_range(0, h - 1);
      end
      if ($urandom_range(0, 9) < 3) load_pixel(c, r);
      else query_pixel(c, r);
    end
  endtask

  initial begin
    logic [15:0] bumps[8];
    logic [15:0] widths[8];
    logic [15:0] heights_cfg[8];
    rst_ni = 1'b0;
    start = 1'b0;
    in_word_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegBumpScale;
    cfg_data_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    query_pixel(0, 0);
    query_pixel(255, 255);
    query_pixel(255, 0);
    set_frame(16'd0, 16'd1, 16'd1);
    query_pixel(0, 0);
    query_pixel(200, 100);
    set_frame(16'd65535, 16'd3, 16'd3);
    query_pixel(2, 2);
    query_pixel(255, 1);

    bumps = '{16'd512, 16'd65535, 16'd1, 16'd300, 16'd0, 16'd2048, 16'd128, 16'd700};
    widths = '{16'd256, 16'd3, 16'd511, 16'd0, 16'd7, 16'd256, 16'd1, 16'd40};
    heights_cfg = '{16'd256, 16'd4, 16'd1, 16'd300, 16'd9, 16'd2, 16'd256, 16'd33};
    foreach (bumps[p]) begin
      set_frame(bumps[p], widths[p], heights_cfg[p]);
      use_gaps = (p % 3 != 2);
      random_items(45);
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d loads and %0d queries across 10 register settings,", sb.n_loads,
             sb.n_queries);
    $display("including zero and oversized frames, wraparound and the straight-up normal.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** height_map_to_normal_map: PASSED **");
    end else begin
      $display("** height_map_to_normal_map: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/hmn_pkg.sv
sv/hmn_ctrl.sv
sv/hmn_path.sv
sv/height_map_to_normal_map.sv
sv/hmn_checker.sv
bench/height_map_to_normal_map_tb.sv
